// ----- hdl/iurc_pkg.sv -----
`default_nettype none

package iurc_pkg;

    localparam int MAX_PACKET_BYTES = 65535;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);

    localparam logic [15:0] PROTO_UDP    = 16'd17;
    localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;
    localparam logic [5:0]  MIN_IP_HDR   = 6'd20;
    localparam logic [15:0] UDP_HDR_LEN  = 16'd8;

    localparam logic [2:0] VERDICT_OK        = 3'd0;
    localparam logic [2:0] VERDICT_IP_CSUM   = 3'd1;
    localparam logic [2:0] VERDICT_UDP_LEN   = 3'd2;
    localparam logic [2:0] VERDICT_UDP_CSUM  = 3'd3;
    localparam logic [2:0] VERDICT_TRUNCATED = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } rx_item_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [31:0] source_address;
        logic [15:0] source_port;
        logic [6:0]  header_bytes;
        logic [15:0] payload_length;
    } res_item_t;

endpackage

`default_nettype wire

// ----- hdl/ipv4_udp_receive_checker_core.sv -----
// IPv4/UDP receive checker.
// rx channel: one packet byte per item, starting at the first IP header byte,
// last_byte set on the final byte. res channel: one verdict item per packet,
// issued for the final byte only (accepted, bad IP checksum, bad UDP length,
// bad UDP checksum, truncated); source address, port, header bytes and
// payload length are filled in only for an accepted packet, zero otherwise.
// Throughput: one byte per cycle; a byte is taken every cycle while the
// result side keeps up, including the first byte of the next packet right
// after a final byte.
// The verdict item for a packet follows the final byte through the input
// register, the running-sum update into a packet snapshot, and the verdict
// into the result register.
// Stall on res holds the result register; the snapshot stage and the input
// register keep filling, and rx stalls only when a final byte finds both
// later stages occupied. Bytes beyond the packet length limit are counted
// no further and not summed.
// Reset clears all packet state and empties every stage.
`default_nettype none

module ipv4_udp_receive_checker_core
    import iurc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      rx_valid,
    output logic           rx_stall,
    input  wire rx_item_t  rx_item,
    output logic           res_valid,
    input  wire logic      res_stall,
    output res_item_t      res_item
);

    localparam logic [POS_W-1:0] MaxPos = POS_W'(MAX_PACKET_BYTES);

    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // byte x is in pseudo-header addresses, UDP ports and length, or payload
    function automatic logic udp_cov(input logic [POS_W-1:0] x, input logic [5:0] hl,
                                     input logic [15:0] ulen);
        logic [POS_W-1:0] d;
        logic             hit;
        d   = x - POS_W'(hl);
        hit = 1'b0;
        if (x >= POS_W'(12) && x < POS_W'(20))
            hit = 1'b1;
        else if (x >= POS_W'(hl))
        begin
            if (d < POS_W'(6))
                hit = 1'b1;
            else if (d >= POS_W'(8) && 17'(d) < {1'b0, ulen})
                hit = 1'b1;
        end
        return hit;
    endfunction

    // input register
    logic       a_v_reg, a_v_next;
    logic [7:0] a_byte_reg;
    logic       a_last_reg;

    // packet state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [5:0]       hl_reg, hl_next;
    logic [15:0]      ip_sum_reg, ip_sum_next;
    logic [15:0]      udp_sum_reg, udp_sum_next;
    logic [7:0]       held_reg, held_next;
    logic [31:0]      src_reg, src_next;
    logic [15:0]      port_reg, port_next;
    logic [15:0]      ulen_reg, ulen_next;
    logic [15:0]      sent_reg, sent_next;

    // packet snapshot
    logic             b_v_reg, b_v_next;
    logic [POS_W-1:0] b_cnt_reg;
    logic [5:0]       b_hl_reg;
    logic [15:0]      b_ip_sum_reg;
    logic [15:0]      b_udp_sum_reg;
    logic [31:0]      b_src_reg;
    logic [15:0]      b_port_reg;
    logic [15:0]      b_ulen_reg;
    logic [15:0]      b_sent_reg;

    // result register
    logic      o_v_reg, o_v_next;
    res_item_t o_item_reg, o_item_next;

    logic o_free, b_free, a_go, rx_take;

    assign o_free   = !o_v_reg || !res_stall;
    assign b_free   = !b_v_reg || o_free;
    assign a_go     = a_v_reg && (!a_last_reg || b_free);
    assign rx_stall = a_v_reg && !a_go;
    assign rx_take  = rx_valid && !rx_stall;

    assign res_valid = o_v_reg;
    assign res_item  = o_item_reg;

    // running state update for the byte in the input register
    logic [5:0]       hl_eff;
    logic [POS_W-1:0] q;
    logic [POS_W-1:0] p_pair;
    logic             cov_p, cov_pair;
    logic [15:0]      word;

    always_comb
    begin
        hl_eff       = (pos_reg == '0) ? {a_byte_reg[3:0], 2'b00} : hl_reg;
        q            = pos_reg - POS_W'(hl_eff);
        p_pair       = pos_reg ^ POS_W'(1);
        word         = {held_reg, a_byte_reg};
        pos_next     = pos_reg;
        hl_next      = hl_eff;
        ip_sum_next  = ip_sum_reg;
        udp_sum_next = udp_sum_reg;
        held_next    = held_reg;
        src_next     = src_reg;
        port_next    = port_reg;
        ulen_next    = ulen_reg;
        sent_next    = sent_reg;
        cov_p        = 1'b0;
        cov_pair     = 1'b0;
        if (pos_reg < MaxPos)
        begin
            if (pos_reg >= POS_W'(12) && pos_reg < POS_W'(16))
                src_next = {src_reg[23:0], a_byte_reg};
            if (pos_reg >= POS_W'(hl_eff))
            begin
                if (q == POS_W'(0))
                    port_next = {a_byte_reg, 8'h00};
                else if (q == POS_W'(1))
                    port_next = {port_reg[15:8], a_byte_reg};
                else if (q == POS_W'(4))
                    ulen_next = {a_byte_reg, 8'h00};
                else if (q == POS_W'(5))
                    ulen_next = {ulen_reg[15:8], a_byte_reg};
                else if (q == POS_W'(6))
                    sent_next = {a_byte_reg, 8'h00};
                else if (q == POS_W'(7))
                    sent_next = {sent_reg[15:8], a_byte_reg};
            end
            cov_p    = udp_cov(pos_reg, hl_eff, ulen_next);
            cov_pair = udp_cov(p_pair, hl_eff, ulen_next);
            if (!pos_reg[0])
            begin
                held_next = a_byte_reg;
                // odd-length coverage: pad the lone high byte with zero
                if (cov_p && !cov_pair)
                    udp_sum_next = fold_add(udp_sum_reg, {a_byte_reg, 8'h00});
            end
            else
            begin
                if (pos_reg < POS_W'(hl_eff))
                    ip_sum_next = fold_add(ip_sum_reg, word);
                if (cov_pair && cov_p)
                    udp_sum_next = fold_add(udp_sum_reg, word);
            end
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // verdict from the snapshot
    logic [6:0]  hl_plus8;
    logic [16:0] hl_ulen;
    logic [17:0] udp_total;
    logic [16:0] udp_fold1;
    logic [15:0] udp_fold2;
    logic [2:0]  verdict;

    always_comb
    begin
        hl_plus8  = {1'b0, b_hl_reg} + 7'd8;
        hl_ulen   = {11'd0, b_hl_reg} + {1'b0, b_ulen_reg};
        udp_total = {2'b00, b_udp_sum_reg} + {2'b00, PROTO_UDP}
                  + {2'b00, b_ulen_reg} + {2'b00, b_sent_reg};
        udp_fold1 = {1'b0, udp_total[15:0]} + {15'd0, udp_total[17:16]};
        udp_fold2 = udp_fold1[15:0] + {15'd0, udp_fold1[16]};
        priority if (b_hl_reg < MIN_IP_HDR)
            verdict = VERDICT_IP_CSUM;
        else if (b_cnt_reg < POS_W'(b_hl_reg))
            verdict = VERDICT_TRUNCATED;
        else if (b_ip_sum_reg != SUM_ALL_ONES)
            verdict = VERDICT_IP_CSUM;
        else if (b_cnt_reg < POS_W'(hl_plus8))
            verdict = VERDICT_TRUNCATED;
        else if (b_ulen_reg < UDP_HDR_LEN || hl_ulen > 17'(b_cnt_reg))
            verdict = VERDICT_UDP_LEN;
        else if (b_sent_reg != 16'd0 && udp_fold2 != SUM_ALL_ONES)
            verdict = VERDICT_UDP_CSUM;
        else
            verdict = VERDICT_OK;

        o_item_next         = '0;
        o_item_next.verdict = verdict;
        if (verdict == VERDICT_OK)
        begin
            o_item_next.source_address = b_src_reg;
            o_item_next.source_port    = b_port_reg;
            o_item_next.header_bytes   = hl_plus8;
            o_item_next.payload_length = b_ulen_reg - UDP_HDR_LEN;
        end
    end

    always_comb
    begin
        a_v_next = a_v_reg;
        if (rx_take)
            a_v_next = 1'b1;
        else if (a_go)
            a_v_next = 1'b0;
        b_v_next = b_v_reg;
        if (b_free)
            b_v_next = a_go && a_last_reg;
        o_v_next = o_v_reg;
        if (o_free)
            o_v_next = b_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg     <= 1'b0;
            b_v_reg     <= 1'b0;
            o_v_reg     <= 1'b0;
            pos_reg     <= '0;
            hl_reg      <= '0;
            ip_sum_reg  <= '0;
            udp_sum_reg <= '0;
            held_reg    <= '0;
            src_reg     <= '0;
            port_reg    <= '0;
            ulen_reg    <= '0;
            sent_reg    <= '0;
        end
        else
        begin
            a_v_reg <= a_v_next;
            b_v_reg <= b_v_next;
            o_v_reg <= o_v_next;
            if (a_go)
            begin
                if (a_last_reg)
                begin
                    // packet done: start the next one from clean state
                    pos_reg     <= '0;
                    hl_reg      <= '0;
                    ip_sum_reg  <= '0;
                    udp_sum_reg <= '0;
                    held_reg    <= '0;
                    src_reg     <= '0;
                    port_reg    <= '0;
                    ulen_reg    <= '0;
                    sent_reg    <= '0;
                end
                else
                begin
                    pos_reg     <= pos_next;
                    hl_reg      <= hl_next;
                    ip_sum_reg  <= ip_sum_next;
                    udp_sum_reg <= udp_sum_next;
                    held_reg    <= held_next;
                    src_reg     <= src_next;
                    port_reg    <= port_next;
                    ulen_reg    <= ulen_next;
                    sent_reg    <= sent_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            a_byte_reg <= rx_item.data_byte;
            a_last_reg <= rx_item.last_byte;
        end
        if (a_go && a_last_reg)
        begin
            b_cnt_reg     <= pos_next;
            b_hl_reg      <= hl_next;
            b_ip_sum_reg  <= ip_sum_next;
            b_udp_sum_reg <= udp_sum_next;
            b_src_reg     <= src_next;
            b_port_reg    <= port_next;
            b_ulen_reg    <= ulen_next;
            b_sent_reg    <= sent_next;
        end
        if (o_free && b_v_reg)
            o_item_reg <= o_item_next;
    end

    a_pkt_restart: assert property (@(posedge clk) disable iff (!rst_n)
        a_go && a_last_reg |=> pos_reg == '0 && udp_sum_reg == 16'd0)
        else $error("packet state not cleared after final byte");

    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= MaxPos)
        else $error("byte position past packet limit");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> a_v_reg && a_last_reg && b_v_reg && o_v_reg)
        else $error("rx stalled with room in the pipeline");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && o_item_reg.verdict != VERDICT_OK |->
            o_item_reg.source_address == 32'd0 && o_item_reg.payload_length == 16'd0)
        else $error("rejected packet carries fields");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg |-> o_item_reg.verdict <= VERDICT_TRUNCATED)
        else $error("verdict code out of range");

endmodule

`default_nettype wire

// ----- sim/ipv4_udp_receive_checker_core_test.sv -----
`default_nettype none

module ipv4_udp_receive_checker_core_test;
    import iurc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int RANDOM_RESULTS = 48;

    typedef enum int {
        F_NONE,
        F_IP_SUM,
        F_SHORT_IHL,
        F_TRUNC,
        F_ULEN_SHORT,
        F_ULEN_LONG,
        F_UDP_SUM,
        F_NO_UDP_SUM,
        F_FORCE_FFFF,
        F_NOISE
    } pkt_fault_t;

    typedef struct packed {
        logic     drain_first;
        rx_item_t item;
    } feed_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      rx_valid = 1'b0;
    logic      rx_stall;
    rx_item_t  rx_item = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res_item;

    feed_t     rx_feed[$];
    res_item_t expected_verdicts[$];
    logic [7:0] pkt_buf[];

    int error_count  = 0;
    int rx_accepted  = 0;
    int results_seen = 0;
    int idle_cycles  = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    // checker state as the block keeps it
    int unsigned chk_pos     = 0;
    logic [5:0]  chk_hlen    = '0;
    logic [15:0] chk_ip_sum  = '0;
    logic [15:0] chk_udp_sum = '0;
    logic [7:0]  chk_high    = '0;
    logic [31:0] chk_src     = '0;
    logic [15:0] chk_port    = '0;
    logic [15:0] chk_ulen    = '0;
    logic [15:0] chk_sent    = '0;

    ipv4_udp_receive_checker_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_item   (rx_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always #1 clk = ~clk;

    function automatic logic [15:0] add_fold(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[16])
            s = s - 17'h0FFFF;
        return s[15:0];
    endfunction

    function automatic bit in_udp_sum(input int unsigned p);
        int unsigned q;
        if (p >= 12 && p < 20)
            return 1'b1;
        if (p < chk_hlen)
            return 1'b0;
        q = p - chk_hlen;
        if (q < 6)
            return 1'b1;
        if (q < 8)
            return 1'b0;
        return q < chk_ulen;
    endfunction

    function automatic bit predict_rx_byte(input rx_item_t it, output res_item_t r);
        int unsigned p;
        int unsigned q;
        int unsigned count;
        int unsigned hl;
        int unsigned ul;
        logic [15:0] s;
        logic [7:0]  b;
        b = it.data_byte;
        p = chk_pos;
        r = '0;
        if (p < MAX_PACKET_BYTES)
        begin
            if (p == 0)
                chk_hlen = {b[3:0], 2'b00};
            if (p >= 12 && p < 16)
                chk_src = {chk_src[23:0], b};
            if (p >= chk_hlen)
            begin
                q = p - chk_hlen;
                case (q)
                    0: chk_port = {b, 8'h00};
                    1: chk_port = chk_port | {8'h00, b};
                    4: chk_ulen = {b, 8'h00};
                    5: chk_ulen = chk_ulen | {8'h00, b};
                    6: chk_sent = {b, 8'h00};
                    7: chk_sent = chk_sent | {8'h00, b};
                    default: ;
                endcase
            end
            if ((p % 2) == 0)
            begin
                chk_high = b;
                // odd-length payload: pad the last byte with zero
                if (in_udp_sum(p) && !in_udp_sum(p + 1))
                    chk_udp_sum = add_fold(chk_udp_sum, {b, 8'h00});
            end
            else
            begin
                if (p < chk_hlen)
                    chk_ip_sum = add_fold(chk_ip_sum, {chk_high, b});
                if (in_udp_sum(p - 1) && in_udp_sum(p))
                    chk_udp_sum = add_fold(chk_udp_sum, {chk_high, b});
            end
            chk_pos = p + 1;
        end

        if (!it.last_byte)
            return 1'b0;

        count = chk_pos;
        hl = chk_hlen;
        ul = chk_ulen;
        if (hl < 20)
            r.verdict = VERDICT_IP_CSUM;
        else if (count < hl)
            r.verdict = VERDICT_TRUNCATED;
        else if (chk_ip_sum != SUM_ALL_ONES)
            r.verdict = VERDICT_IP_CSUM;
        else if (count < hl + 8)
            r.verdict = VERDICT_TRUNCATED;
        else if (ul < 8 || hl + ul > count)
            r.verdict = VERDICT_UDP_LEN;
        else
        begin
            r.verdict = VERDICT_OK;
            if (chk_sent != 16'h0000)
            begin
                s = add_fold(chk_udp_sum, PROTO_UDP);
                s = add_fold(s, chk_ulen);
                s = add_fold(s, chk_sent);
                if (s != SUM_ALL_ONES)
                    r.verdict = VERDICT_UDP_CSUM;
            end
        end
        if (r.verdict == VERDICT_OK)
        begin
            r.source_address = chk_src;
            r.source_port    = chk_port;
            r.header_bytes   = 7'(hl + 8);
            r.payload_length = 16'(ul - 8);
        end

        chk_pos     = 0;
        chk_hlen    = '0;
        chk_ip_sum  = '0;
        chk_udp_sum = '0;
        chk_high    = '0;
        chk_src     = '0;
        chk_port    = '0;
        chk_ulen    = '0;
        chk_sent    = '0;
        return 1'b1;
    endfunction

    function automatic logic [15:0] udp_coverage_sum(input int hl, input int ulen);
        logic [15:0] s;
        logic [7:0]  lo;
        int          i;
        s = '0;
        for (i = 12; i < 20; i += 2)
            s = add_fold(s, {pkt_buf[i], pkt_buf[i + 1]});
        s = add_fold(s, PROTO_UDP);
        s = add_fold(s, ulen[15:0]);
        for (i = hl; i < hl + ulen; i += 2)
        begin
            lo = (i + 1 < hl + ulen) ? pkt_buf[i + 1] : 8'h00;
            s = add_fold(s, {pkt_buf[i], lo});
        end
        return s;
    endfunction

    // Build one packet into pkt_buf with valid checksums, apply the fault, queue its bytes.
    task automatic queue_udp_packet(input int ihl, input int plen, input int trail,
                                    input pkt_fault_t fault, input int cut,
                                    input bit drain_first, input bit fixed_src,
                                    input logic [31:0] src_val);
        int          hl;
        int          ulen;
        int          n;
        int          len;
        int          i;
        logic [15:0] s;
        logic [15:0] c;
        feed_t       f;
        hl = ihl * 4;
        ulen = plen + 8;
        n = (fault == F_NOISE) ? plen : hl + ulen + trail;
        pkt_buf = new[n];
        foreach (pkt_buf[k])
            pkt_buf[k] = 8'($urandom_range(0, 255));
        len = n;
        if (fault != F_NOISE)
        begin
            pkt_buf[0] = {4'h4, ihl[3:0]};
            pkt_buf[9] = 8'd17;
            if (fixed_src)
            begin
                {pkt_buf[12], pkt_buf[13], pkt_buf[14], pkt_buf[15]} = src_val;
                {pkt_buf[hl], pkt_buf[hl + 1]} = src_val[15:0];
            end
            {pkt_buf[10], pkt_buf[11]} = 16'h0000;
            s = '0;
            for (i = 0; i < hl; i += 2)
                s = add_fold(s, {pkt_buf[i], pkt_buf[i + 1]});
            {pkt_buf[10], pkt_buf[11]} = ~s;

            {pkt_buf[hl + 4], pkt_buf[hl + 5]} = ulen[15:0];
            {pkt_buf[hl + 6], pkt_buf[hl + 7]} = 16'h0000;
            if (fault == F_FORCE_FFFF)
                {pkt_buf[hl + 8], pkt_buf[hl + 9]} = 16'h0000;
            s = udp_coverage_sum(hl, ulen);
            // tune the first payload word so the sum is zero and 0xFFFF is sent
            if (fault == F_FORCE_FFFF)
            begin
                {pkt_buf[hl + 8], pkt_buf[hl + 9]} = ~s;
                s = udp_coverage_sum(hl, ulen);
            end
            c = ~s;
            if (c == 16'h0000)
                c = 16'hFFFF;
            {pkt_buf[hl + 6], pkt_buf[hl + 7]} = c;

            case (fault)
                F_IP_SUM:     pkt_buf[10] = pkt_buf[10] ^ 8'($urandom_range(1, 255));
                F_SHORT_IHL:  pkt_buf[0] = {4'h4, 4'($urandom_range(0, 4))};
                F_TRUNC:      len = (cut > 0) ? cut : $urandom_range(1, n - 1);
                F_ULEN_SHORT: {pkt_buf[hl + 4], pkt_buf[hl + 5]} = 16'($urandom_range(0, 7));
                F_ULEN_LONG:
                    {pkt_buf[hl + 4], pkt_buf[hl + 5]} =
                        16'(ulen + trail + $urandom_range(1, 20));
                F_UDP_SUM:    pkt_buf[hl + 6] = pkt_buf[hl + 6] ^ 8'($urandom_range(1, 255));
                F_NO_UDP_SUM: {pkt_buf[hl + 6], pkt_buf[hl + 7]} = 16'h0000;
                default: ;
            endcase
        end
        for (i = 0; i < len; i++)
        begin
            f.drain_first    = drain_first && (i == 0);
            f.item.data_byte = pkt_buf[i];
            f.item.last_byte = (i == len - 1);
            rx_feed.push_back(f);
        end
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // sender: offer the next queued byte unless idling or waiting for results to drain
    always @(posedge clk or negedge rst_n)
    begin : drive_rx
        res_item_t verdict;
        feed_t     head;
        bit        offer;
        bit        gap;
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
        end
        else
        begin
            if (rx_valid && !rx_stall)
            begin
                rx_accepted++;
                if (predict_rx_byte(rx_item, verdict))
                    expected_verdicts.push_back(verdict);
            end
            if (!rx_valid || !rx_stall)
            begin
                offer = 1'b0;
                gap = !(rx_accepted >= 1000 && rx_accepted < 1500)
                      && ($urandom_range(0, 99) < 8);
                if (rx_feed.size() != 0)
                begin
                    head = rx_feed[0];
                    offer = !gap && !(head.drain_first && expected_verdicts.size() != 0);
                end
                if (offer)
                begin
                    head = rx_feed.pop_front();
                    rx_item <= head.item;
                end
                rx_valid <= offer;
            end
        end
    end

    // receiver: check each verdict item against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : watch_res
        res_item_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (expected_verdicts.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with none expected, expected nothing, got %p",
                             $time, res_item);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    compare_field("verdict", want.verdict, res_item.verdict);
                    compare_field("source_address", want.source_address,
                                  res_item.source_address);
                    compare_field("source_port", want.source_port, res_item.source_port);
                    compare_field("header_bytes", want.header_bytes, res_item.header_bytes);
                    compare_field("payload_length", want.payload_length,
                                  res_item.payload_length);
                end
            end
            // hold off once for a long stretch so the block backs up into rx
            if (hold_left > 0)
                hold_left--;
            else if (!hold_done && results_seen >= 15)
            begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            res_stall <= (hold_left > 0)
                         || (!(results_seen >= 30 && results_seen < 45)
                             && ($urandom_range(0, 99) < 8));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        int         base;
        int         random_items;
        int         random_results;
        int         roll;
        int         ihl;
        int         plen;
        int         trail;
        bit         first;
        pkt_fault_t fault;

        queue_udp_packet(5, 0, 0, F_NONE, 0, 1'b0, 1'b1, 32'h0000_0000);
        queue_udp_packet(15, 33, 0, F_NONE, 0, 1'b0, 1'b1, 32'hFFFF_FFFF);
        queue_udp_packet(5, 7, 0, F_NO_UDP_SUM, 0, 1'b0, 1'b0, '0);
        queue_udp_packet(6, 4, 0, F_FORCE_FFFF, 0, 1'b0, 1'b0, '0);
        queue_udp_packet(5, 10, 0, F_IP_SUM, 0, 1'b0, 1'b0, '0);
        queue_udp_packet(5, 10, 0, F_SHORT_IHL, 0, 1'b0, 1'b0, '0);
        queue_udp_packet(5, 10, 0, F_TRUNC, 13, 1'b0, 1'b0, '0);
        queue_udp_packet(5, 10, 0, F_TRUNC, 24, 1'b0, 1'b0, '0);
        queue_udp_packet(7, 3, 0, F_TRUNC, 37, 1'b0, 1'b0, '0);
        queue_udp_packet(5, 10, 0, F_ULEN_SHORT, 0, 1'b0, 1'b0, '0);
        queue_udp_packet(5, 10, 0, F_ULEN_LONG, 0, 1'b0, 1'b0, '0);
        queue_udp_packet(5, 10, 0, F_UDP_SUM, 0, 1'b0, 1'b0, '0);
        queue_udp_packet(5, 9, 5, F_NONE, 0, 1'b0, 1'b0, '0);
        queue_udp_packet(0, 1, 0, F_NOISE, 0, 1'b0, 1'b0, '0);

        random_items = 0;
        random_results = 0;
        first = 1'b1;
        while (random_items < RANDOM_ITEMS || random_results < RANDOM_RESULTS)
        begin
            ihl = ($urandom_range(0, 99) < 80) ? 5 : $urandom_range(6, 15);
            plen = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 24)
                                                : $urandom_range(25, 200);
            trail = ($urandom_range(0, 99) < 80) ? 0 : $urandom_range(1, 6);
            roll = $urandom_range(0, 99);
            if (roll < 60)       fault = F_NONE;
            else if (roll < 65)  fault = F_IP_SUM;
            else if (roll < 69)  fault = F_SHORT_IHL;
            else if (roll < 76)  fault = F_TRUNC;
            else if (roll < 80)  fault = F_ULEN_SHORT;
            else if (roll < 85)  fault = F_ULEN_LONG;
            else if (roll < 91)  fault = F_UDP_SUM;
            else if (roll < 95)  fault = F_NO_UDP_SUM;
            else if (roll < 97)  fault = F_FORCE_FFFF;
            else                 fault = F_NOISE;
            if (fault == F_FORCE_FFFF && plen < 2)
                plen = 2;
            if (fault == F_NOISE)
                plen = $urandom_range(1, 48);
            base = rx_feed.size();
            queue_udp_packet(ihl, plen, trail, fault, 0, first, 1'b0, '0);
            random_items += rx_feed.size() - base;
            random_results++;
            first = 1'b0;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_feed.size() != 0 || rx_valid || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/iurc_pkg.sv
hdl/ipv4_udp_receive_checker_core.sv
sim/ipv4_udp_receive_checker_core_test.sv
